[rtl/core/ijm_pkg.sv]
// Shared widths, register codes and stage records for the I/Q jammer mixer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ijm_pkg;

	localparam int FRAC_BITS = 8;
	localparam int INDEX_BITS = 40;
	localparam int SAMP_W = 24;
	localparam int JG_W = 24;
	localparam int JG_FRAC = 16;
	localparam int CG_W = 17;
	localparam int CFG_W = 40;
	localparam int OUT_W = 16;
	localparam int ACC_W = 63;
	localparam int CNT_W = 40;
	localparam int SCALED_W = SAMP_W + JG_W;
	localparam int SUM_W = SCALED_W + 1;
	localparam int P_W = SUM_W + CG_W;
	localparam int MAG_W = P_W - 32;
	localparam int Q_W = P_W - 32 - FRAC_BITS;
	localparam int JMAG_W = SCALED_W - JG_FRAC;
	localparam int CSQ_W = 2 * SAMP_W - 1;
	localparam int CSUM_W = CSQ_W + 1;
	localparam int SQ_IN_W = 32;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(32767);
	localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(32768);

	typedef enum logic [1:0] {
		REG_JAMMER_GAIN,
		REG_COMMON_GAIN,
		REG_PLATEAU_START,
		REG_PLATEAU_END
	} cfg_reg_t;

	typedef struct packed {
		logic [OUT_W-1:0] out;
		logic clip;
		logic [MAG_W-1:0] mag;
		logic [CSQ_W-1:0] csq;
		logic [ACC_W-1:0] jsq;
		logic [ACC_W-1:0] msq;
	} lane_res_t;

	typedef struct packed {
		logic [OUT_W-1:0] out_i;
		logic [OUT_W-1:0] out_q;
		logic [CNT_W-1:0] peak;
		logic [ACC_W-1:0] clean_e;
		logic [ACC_W-1:0] jammer_e;
		logic [ACC_W-1:0] mixed_e;
		logic [CNT_W-1:0] plateau_cnt;
		logic [CNT_W-1:0] clip_cnt;
		logic [CNT_W-1:0] sample_cnt;
	} metrics_t;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
		input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] c,
		input logic [1:0] n);
		logic [CNT_W:0] s;
		s = {1'b0, c} + (CNT_W+1)'(n);
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

[rtl/core/iq_jammer_mixer_sc16.sv]
// I/Q jammer mixer, top level: configuration registers, stream handshake and output word.
// Depends on ijm_pkg, ijm_lane and ijm_merge.
// Each input word carries one complex sample; an I lane and a Q lane mix it side by side
// through five stages (jammer scaling, sum, common gain, rounding and saturation, squaring)
// and a two-stage merge updates the peak, the plateau power sums and the counters. One word
// is in flight at a time: it passes the lane stages, the merge stages and a done flag into
// the output register, and the next word is accepted only once that result is loaded there;
// the output register holds a finished result while the next word is already being mixed.
`timescale 1ns / 1ps

module iq_jammer_mixer_sc16 (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [1:0] cfg_index,
	input logic [ijm_pkg::CFG_W-1:0] cfg_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// sample index, clean I, clean Q, jammer I, jammer Q
	input logic [135:0] s_axis_tdata,
	// restart_metrics
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// out_i, out_q, peak_level, clean_energy, jammer_energy, mixed_energy,
	// plateau_total, clip_total, sample_total, zero padding
	output logic [383:0] m_axis_tdata
);
	import ijm_pkg::*;

	logic [JG_W-1:0] jammer_gain_q;
	logic [CG_W-1:0] sum_gain_q;
	logic [INDEX_BITS-1:0] plateau_start_q, plateau_end_q;
	logic busy_q, done_q, out_valid_q;
	logic restart_q, plateau_q;
	logic [383:0] out_data_q;

	logic accept, load_out;
	logic [INDEX_BITS-1:0] sample_index;
	logic [SAMP_W-1:0] clean_i, clean_q, jam_i, jam_q;
	logic lane_i_valid, lane_q_valid, merge_done;
	lane_res_t lane_i_res, lane_q_res;
	metrics_t metrics;

	assign sample_index = s_axis_tdata[39:0];
	assign clean_i = s_axis_tdata[63:40];
	assign clean_q = s_axis_tdata[87:64];
	assign jam_i = s_axis_tdata[111:88];
	assign jam_q = s_axis_tdata[135:112];

	assign s_axis_tready = !busy_q;
	assign accept = s_axis_tvalid && !busy_q;
	assign load_out = done_q && (!out_valid_q || m_axis_tready);

	ijm_lane u_lane_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.clean(clean_i),
		.jam(jam_i),
		.jammer_gain(jammer_gain_q),
		.sum_gain(sum_gain_q),
		.res_valid(lane_i_valid),
		.res(lane_i_res)
	);

	ijm_lane u_lane_q (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.clean(clean_q),
		.jam(jam_q),
		.jammer_gain(jammer_gain_q),
		.sum_gain(sum_gain_q),
		.res_valid(lane_q_valid),
		.res(lane_q_res)
	);

	ijm_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(lane_i_valid && lane_q_valid),
		.lane_i(lane_i_res),
		.lane_q(lane_q_res),
		.restart(restart_q),
		.in_plateau(plateau_q),
		.done(merge_done),
		.metrics(metrics)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jammer_gain_q <= JG_W'(65536);
			sum_gain_q <= CG_W'(65536);
			plateau_start_q <= '0;
			plateau_end_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_JAMMER_GAIN: jammer_gain_q <= cfg_data[JG_W-1:0];
					REG_COMMON_GAIN: sum_gain_q <= cfg_data[CG_W-1:0];
					REG_PLATEAU_START: plateau_start_q <= cfg_data[INDEX_BITS-1:0];
					REG_PLATEAU_END: plateau_end_q <= cfg_data[INDEX_BITS-1:0];
				endcase
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load_out) begin
				busy_q <= 1'b0;
			end
			if (merge_done) begin
				done_q <= 1'b1;
			end else if (load_out) begin
				done_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			restart_q <= s_axis_tuser;
			plateau_q <= (sample_index >= plateau_start_q) && (sample_index < plateau_end_q);
		end
		if (load_out) begin
			out_data_q <= {3'b000, metrics.sample_cnt, metrics.clip_cnt, metrics.plateau_cnt,
				metrics.mixed_e, metrics.jammer_e, metrics.clean_e, metrics.peak,
				metrics.out_q, metrics.out_i};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

[rtl/core/ijm_lane.sv]
// One mixing lane: scales the jammer, adds the clean sample, applies the common gain,
// rounds, saturates and squares the magnitudes. Depends on ijm_pkg.
`timescale 1ns / 1ps

module ijm_lane (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [ijm_pkg::SAMP_W-1:0] clean,
	input logic [ijm_pkg::SAMP_W-1:0] jam,
	input logic [ijm_pkg::JG_W-1:0] jammer_gain,
	input logic [ijm_pkg::CG_W-1:0] sum_gain,
	output logic res_valid,
	output ijm_pkg::lane_res_t res
);
	import ijm_pkg::*;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;

	logic signed [SCALED_W:0] prod;
	logic signed [2*SAMP_W-1:0] csq_full;
	logic signed [SCALED_W-1:0] scaled_s1;
	logic [SAMP_W-1:0] clean_s1;
	logic [CSQ_W-1:0] csq_s1;

	logic [SUM_W-1:0] sum;
	logic [SCALED_W-1:0] ja, ja_rnd;
	logic [SUM_W-1:0] a_s2;
	logic neg_s2;
	logic [JMAG_W-1:0] jmag_s2;
	logic [CSQ_W-1:0] csq_s2;

	logic [P_W-1:0] p_s3;
	logic neg_s3;
	logic [JMAG_W-1:0] jmag_s3;
	logic [CSQ_W-1:0] csq_s3;

	logic [P_W-1:0] p_rnd_m, p_rnd_q;
	logic [Q_W-1:0] q, q_sat, lim;
	logic [OUT_W-1:0] out_s4;
	logic clip_s4;
	logic [MAG_W-1:0] mag_s4;
	logic [JMAG_W-1:0] jmag_s4;
	logic [CSQ_W-1:0] csq_s4;

	logic [2*SQ_IN_W-1:0] msq_full, jsq_full;
	lane_res_t res_s5;

	assign prod = $signed(jam) * $signed({1'b0, jammer_gain});
	assign csq_full = $signed(clean) * $signed(clean);

	assign sum = {{(SUM_W-SAMP_W-JG_FRAC){clean_s1[SAMP_W-1]}}, clean_s1, {JG_FRAC{1'b0}}}
		+ {scaled_s1[SCALED_W-1], scaled_s1};
	assign ja = scaled_s1[SCALED_W-1] ? SCALED_W'(-scaled_s1) : SCALED_W'(scaled_s1);
	assign ja_rnd = ja + SCALED_W'(1 << (JG_FRAC - 1));

	assign p_rnd_m = p_s3 + (P_W'(1) << 31);
	assign p_rnd_q = p_s3 + (P_W'(1) << (FRAC_BITS + 31));
	assign q = p_rnd_q[P_W-1:32+FRAC_BITS];
	assign lim = neg_s3 ? NEG_LIMIT : POS_LIMIT;
	assign q_sat = (q > lim) ? lim : q;

	assign msq_full = mag_s4[SQ_IN_W-1:0] * mag_s4[SQ_IN_W-1:0];
	assign jsq_full = (2*SQ_IN_W)'(jmag_s4) * (2*SQ_IN_W)'(jmag_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			v1_s1 <= in_valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			scaled_s1 <= prod[SCALED_W-1:0];
			clean_s1 <= clean;
			csq_s1 <= csq_full[CSQ_W-1:0];
		end
		if (v1_s1) begin
			neg_s2 <= sum[SUM_W-1];
			a_s2 <= sum[SUM_W-1] ? SUM_W'(-sum) : sum;
			jmag_s2 <= ja_rnd[SCALED_W-1:JG_FRAC];
			csq_s2 <= csq_s1;
		end
		if (v2_s2) begin
			p_s3 <= P_W'(a_s2) * P_W'(sum_gain);
			neg_s3 <= neg_s2;
			jmag_s3 <= jmag_s2;
			csq_s3 <= csq_s2;
		end
		if (v3_s3) begin
			mag_s4 <= p_rnd_m[P_W-1:32];
			clip_s4 <= q > lim;
			out_s4 <= neg_s3 ? OUT_W'(-q_sat) : OUT_W'(q_sat);
			jmag_s4 <= jmag_s3;
			csq_s4 <= csq_s3;
		end
		if (v4_s4) begin
			res_s5.out <= out_s4;
			res_s5.clip <= clip_s4;
			res_s5.mag <= mag_s4;
			res_s5.csq <= csq_s4;
			res_s5.msq <= (mag_s4[MAG_W-1:SQ_IN_W] != '0 || msq_full[2*SQ_IN_W-1])
				? ACC_MAX : msq_full[ACC_W-1:0];
			res_s5.jsq <= jsq_full[2*SQ_IN_W-1] ? ACC_MAX : jsq_full[ACC_W-1:0];
		end
	end

	assign res_valid = v5_s5;
	assign res = res_s5;

endmodule

[rtl/core/ijm_merge.sv]
// Merges the I and Q lane results into the peak, power sums and counters.
// Depends on ijm_pkg.
`timescale 1ns / 1ps

module ijm_merge (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input ijm_pkg::lane_res_t lane_i,
	input ijm_pkg::lane_res_t lane_q,
	input logic restart,
	input logic in_plateau,
	output logic done,
	output ijm_pkg::metrics_t metrics
);
	import ijm_pkg::*;

	logic v_s1, v_s2;
	logic [OUT_W-1:0] out_i_s1, out_q_s1;
	logic [CNT_W-1:0] mag_s1;
	logic [CSUM_W-1:0] csum_s1;
	logic [ACC_W-1:0] jsum_s1, msum_s1;
	logic [1:0] clips_s1;
	logic [MAG_W-1:0] mag_max;

	logic [ACC_W-1:0] clean_q, jam_pow_q, mixed_q;
	logic [CNT_W-1:0] peak_q, plateau_q, clip_q, sample_q;
	logic [OUT_W-1:0] out_i_q, out_q_q;

	logic [ACC_W-1:0] clean_b, jammer_b, mixed_b;
	logic [CNT_W-1:0] peak_b, plateau_b, clip_b, sample_b;

	assign mag_max = (lane_i.mag > lane_q.mag) ? lane_i.mag : lane_q.mag;

	assign clean_b = restart ? '0 : clean_q;
	assign jammer_b = restart ? '0 : jam_pow_q;
	assign mixed_b = restart ? '0 : mixed_q;
	assign peak_b = restart ? '0 : peak_q;
	assign plateau_b = restart ? '0 : plateau_q;
	assign clip_b = restart ? '0 : clip_q;
	assign sample_b = restart ? '0 : sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			clean_q <= '0;
			jam_pow_q <= '0;
			mixed_q <= '0;
			peak_q <= '0;
			plateau_q <= '0;
			clip_q <= '0;
			sample_q <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			if (v_s1) begin
				if (in_plateau) begin
					clean_q <= sat_add(clean_b, ACC_W'(csum_s1));
					jam_pow_q <= sat_add(jammer_b, jsum_s1);
					mixed_q <= sat_add(mixed_b, msum_s1);
					plateau_q <= sat_cnt(plateau_b, 2'd1);
				end else begin
					clean_q <= clean_b;
					jam_pow_q <= jammer_b;
					mixed_q <= mixed_b;
					plateau_q <= plateau_b;
				end
				peak_q <= (mag_s1 > peak_b) ? mag_s1 : peak_b;
				clip_q <= sat_cnt(clip_b, clips_s1);
				sample_q <= sat_cnt(sample_b, 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			out_i_s1 <= lane_i.out;
			out_q_s1 <= lane_q.out;
			mag_s1 <= CNT_W'(mag_max);
			csum_s1 <= CSUM_W'(lane_i.csq) + CSUM_W'(lane_q.csq);
			jsum_s1 <= sat_add(lane_i.jsq, lane_q.jsq);
			msum_s1 <= sat_add(lane_i.msq, lane_q.msq);
			clips_s1 <= 2'(lane_i.clip) + 2'(lane_q.clip);
		end
		if (v_s1) begin
			out_i_q <= out_i_s1;
			out_q_q <= out_q_s1;
		end
	end

	assign done = v_s2;
	assign metrics.out_i = out_i_q;
	assign metrics.out_q = out_q_q;
	assign metrics.peak = peak_q;
	assign metrics.clean_e = clean_q;
	assign metrics.jammer_e = jam_pow_q;
	assign metrics.mixed_e = mixed_q;
	assign metrics.plateau_cnt = plateau_q;
	assign metrics.clip_cnt = clip_q;
	assign metrics.sample_cnt = sample_q;

endmodule
